[hw/rtl/psm_pkg.sv]
// ----------------------------------------------------------------------------
// psm_pkg
// Shared constants, controller states and the command/status bundles that
// join the controller and the datapath of the period average speed meter.
// ----------------------------------------------------------------------------
package psm_pkg;

    localparam int unsigned LIMIT_W   = 8;
    localparam int unsigned SCALE_W   = 32;
    localparam int unsigned TICKS_W   = 16;
    localparam int unsigned SUM_W     = 24;
    localparam int unsigned COUNT_W   = 8;
    localparam int unsigned OUT_W     = 32;
    localparam int unsigned NUM_W     = SCALE_W + COUNT_W;
    localparam int unsigned DIV_STEPS = NUM_W;
    localparam int unsigned STEP_W    = $clog2(DIV_STEPS);
    localparam int unsigned CFG_IDX_W = 1;
    localparam int unsigned CFG_DAT_W = 32;

    localparam logic [CFG_IDX_W-1:0] CFG_LIMIT = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_SCALE = 1'b1;

    localparam logic [LIMIT_W-1:0] LIMIT_RESET   = 8'd15;
    localparam logic [SCALE_W-1:0] SCALE_RESET   = 32'd251460000;
    localparam logic [SCALE_W-1:0] TICKS_PER_SEC = 32'd62500;
    localparam logic [SUM_W-1:0]   OVERFLOW_SUM  = 24'h00FFFF;
    localparam logic [SUM_W-1:0]   SUM_MAX       = 24'hFFFFFF;
    localparam logic [STEP_W-1:0]  STEP_LAST     = STEP_W'(DIV_STEPS - 1);

    localparam logic OP_CAPTURE  = 1'b0;
    localparam logic OP_OVERFLOW = 1'b1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_MUL,
        ST_DIV,
        ST_DONE
    } t_state;

    typedef struct packed {
        logic load;      // input beat taken this cycle
        logic mul;       // form numerators
        logic step;      // one divider step
        logic out_load;  // capture quotients into the output register
    } t_cmd;

    typedef struct packed {
        logic report;    // current input beat produces a result
        logic div_last;  // final divider step in progress
    } t_status;

endpackage

[hw/rtl/period_average_speed_meter_top.sv]
// ----------------------------------------------------------------------------
// period_average_speed_meter_top
// Period-averaging frequency and wind-speed meter driven by timer events.
// ----------------------------------------------------------------------------
// A capture beat that does not complete a report is absorbed without
// leaving the idle state. A beat that reports (count reaches
// captures_per_report, or any overflow beat) is taken, then count is
// multiplied by the tick rate and the scale, then the pair of bit-serial
// restoring dividers run, and then the output register is loaded once it
// is free. New input is taken while a finished result still waits in the
// output register; only one event is in work at a time. A zero period sum
// or a quotient above 32 bits gives all ones.
module period_average_speed_meter_top (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [psm_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [psm_pkg::CFG_DAT_W-1:0] i_cfg_data,
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  logic                          i_opcode,
    input  logic [psm_pkg::TICKS_W-1:0]   i_period_ticks,
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output logic [psm_pkg::OUT_W-1:0]     o_frequency_hz,
    output logic [psm_pkg::OUT_W-1:0]     o_air_speed,
    output logic                          o_timed_out
);
    import psm_pkg::*;

    t_cmd    cmd;
    t_status status;

    psm_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .i_status    (status),
        .o_cmd       (cmd)
    );

    psm_dp u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .i_opcode       (i_opcode),
        .i_period_ticks (i_period_ticks),
        .i_cmd          (cmd),
        .o_status       (status),
        .o_frequency_hz (o_frequency_hz),
        .o_air_speed    (o_air_speed),
        .o_timed_out    (o_timed_out)
    );

endmodule

[hw/rtl/psm_ctrl.sv]
// ----------------------------------------------------------------------------
// psm_ctrl
// Sequencer for the meter: takes input beats, runs the multiply and the
// bit-serial divide on a report, and owns the output valid flag.
// ----------------------------------------------------------------------------
module psm_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_ready,
    output logic             o_out_valid,
    input  logic             i_out_ready,
    input  psm_pkg::t_status i_status,
    output psm_pkg::t_cmd    o_cmd
);
    import psm_pkg::*;

    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    always_comb begin
        n_state        = r_state;
        n_out_valid    = r_out_valid;
        o_cmd          = '0;
        o_in_ready     = 1'b0;
        if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end
        case (r_state)
            ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    if (i_status.report) begin
                        n_state = ST_MUL;
                    end
                end
            end
            ST_MUL: begin
                o_cmd.mul = 1'b1;
                n_state   = ST_DIV;
            end
            ST_DIV: begin
                o_cmd.step = 1'b1;
                if (i_status.div_last) begin
                    n_state = ST_DONE;
                end
            end
            ST_DONE: begin
                // wait for the output register to free up
                if (!r_out_valid || i_out_ready) begin
                    o_cmd.out_load = 1'b1;
                    n_out_valid    = 1'b1;
                    n_state        = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    assign o_out_valid = r_out_valid;

endmodule

[hw/rtl/psm_dp.sv]
// ----------------------------------------------------------------------------
// psm_dp
// Datapath: configuration registers, running period sum and count, the
// numerator multipliers, two restoring dividers and the output register.
// ----------------------------------------------------------------------------
module psm_dp (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_cfg_we,
    input  logic [psm_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [psm_pkg::CFG_DAT_W-1:0]      i_cfg_data,
    input  logic                               i_opcode,
    input  logic [psm_pkg::TICKS_W-1:0]        i_period_ticks,
    input  psm_pkg::t_cmd                      i_cmd,
    output psm_pkg::t_status                   o_status,
    output logic [psm_pkg::OUT_W-1:0]          o_frequency_hz,
    output logic [psm_pkg::OUT_W-1:0]          o_air_speed,
    output logic                               o_timed_out
);
    import psm_pkg::*;

    logic [LIMIT_W-1:0] r_limit;
    logic [SCALE_W-1:0] r_scale;
    logic [SUM_W-1:0]   r_sum, n_sum;
    logic [COUNT_W-1:0] r_count, n_count;
    logic [SUM_W:0]     sum_add;

    logic [SUM_W-1:0]   r_div;
    logic [COUNT_W-1:0] r_mcount;
    logic               r_flag;
    logic [STEP_W-1:0]  r_step;

    logic [NUM_W-1:0]   r_quo_f, r_quo_w;
    logic [SUM_W-1:0]   r_rem_f, r_rem_w;
    logic [SUM_W:0]     sh_f, sh_w;
    logic               ge_f, ge_w;
    logic [SUM_W:0]     sub_f, sub_w;

    logic [OUT_W-1:0]   r_freq, r_wind;
    logic               r_timed_out;

    // configuration
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_limit <= LIMIT_RESET;
            r_scale <= SCALE_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_LIMIT: r_limit <= i_cfg_data[LIMIT_W-1:0];
                CFG_SCALE: r_scale <= i_cfg_data[SCALE_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // event accumulation
    always_comb begin
        n_count = r_count + COUNT_W'(1);
        sum_add = {1'b0, r_sum} + (SUM_W+1)'(i_period_ticks);
        if (i_opcode == OP_OVERFLOW) begin
            n_sum = OVERFLOW_SUM;
        end else if (sum_add[SUM_W]) begin
            n_sum = SUM_MAX;
        end else begin
            n_sum = sum_add[SUM_W-1:0];
        end
        o_status.report   = (i_opcode == OP_OVERFLOW) || (n_count >= r_limit);
        o_status.div_last = (r_step == STEP_LAST);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sum   <= '0;
            r_count <= '0;
        end else if (i_cmd.load) begin
            if (o_status.report) begin
                r_sum   <= '0;
                r_count <= '0;
            end else begin
                r_sum   <= n_sum;
                r_count <= n_count;
            end
        end
    end

    // operands held for the report
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_div    <= n_sum;
            r_mcount <= n_count;
            r_flag   <= i_opcode;
        end
    end

    // restoring divide, one quotient bit per cycle; a zero divisor yields
    // an all-ones quotient, which saturates below
    always_comb begin
        sh_f  = {r_rem_f, r_quo_f[NUM_W-1]};
        sh_w  = {r_rem_w, r_quo_w[NUM_W-1]};
        ge_f  = (sh_f >= {1'b0, r_div});
        ge_w  = (sh_w >= {1'b0, r_div});
        sub_f = sh_f - {1'b0, r_div};
        sub_w = sh_w - {1'b0, r_div};
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.mul) begin
            r_quo_f <= NUM_W'(TICKS_PER_SEC) * NUM_W'(r_mcount);
            r_quo_w <= NUM_W'(r_scale) * NUM_W'(r_mcount);
            r_rem_f <= '0;
            r_rem_w <= '0;
            r_step  <= '0;
        end else if (i_cmd.step) begin
            r_quo_f <= {r_quo_f[NUM_W-2:0], ge_f};
            r_quo_w <= {r_quo_w[NUM_W-2:0], ge_w};
            r_rem_f <= ge_f ? sub_f[SUM_W-1:0] : sh_f[SUM_W-1:0];
            r_rem_w <= ge_w ? sub_w[SUM_W-1:0] : sh_w[SUM_W-1:0];
            r_step  <= r_step + STEP_W'(1);
        end
    end

    // output register with saturation
    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_freq      <= (|r_quo_f[NUM_W-1:OUT_W]) ? '1 : r_quo_f[OUT_W-1:0];
            r_wind      <= (|r_quo_w[NUM_W-1:OUT_W]) ? '1 : r_quo_w[OUT_W-1:0];
            r_timed_out <= r_flag;
        end
    end

    assign o_frequency_hz = r_freq;
    assign o_air_speed    = r_wind;
    assign o_timed_out    = r_timed_out;

endmodule
